@@ rtl/cfa_pkg.sv @@
// Shared types and constants of the contiguous frame allocator.
package cfa_pkg;

    localparam int MAX_FRAMES_DEF = 1024;
    localparam int ADDR_W = 20;
    localparam int LEN_W = 11;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_MARK    = 2'd2,
        OP_INIT    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_BAD_ADDR = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FS_FREE   = 2'b00,
        FS_UNUSED = 2'b01,
        FS_HEAD   = 2'b10,
        FS_USED   = 2'b11
    } frame_st_t;

    typedef enum logic [1:0] {
        CFG_POOL_BASE    = 2'd0,
        CFG_POOL_SIZE    = 2'd1,
        CFG_INFO_IN_POOL = 2'd2,
        CFG_NONE         = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] frame_addr;
        logic [LEN_W-1:0]  run_len;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] first_frame;
        logic [1:0]        status;
        logic [LEN_W-1:0]  free_count;
    } rsp_t;

    typedef struct packed {
        logic       shift;
        logic [1:0] tail;
    } chain_ctl_t;

endpackage

@@ rtl/cfa_cell.sv @@
// One cell of the frame ring: holds the 2-bit state of one frame.
module cfa_cell
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic [1:0] d,
    output logic [1:0] q
);

    logic [1:0] state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfa_pkg::FS_FREE;
        end
        else if (shift)
        begin
            state_reg <= d;
        end
    end

    assign q = state_reg;

endmodule

@@ rtl/cfa_chain.sv @@
// Row of frame cells; each shift moves every state one cell towards the head.
module cfa_chain
#(
    parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfa_pkg::chain_ctl_t ctl,
    output logic [1:0]          head
);

    logic [1:0] q [MAX_FRAMES];

    for (genvar k = 0; k < MAX_FRAMES; k++)
    begin : g_cell
        logic [1:0] d;
        if (k == MAX_FRAMES - 1)
        begin : g_tail
            assign d = ctl.tail;
        end
        else
        begin : g_mid
            assign d = q[k+1];
        end
        cfa_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (ctl.shift),
            .d     (d),
            .q     (q[k])
        );
    end

    assign head = q[0];

endmodule

@@ rtl/contiguous_frame_allocator.sv @@
// Contiguous frame allocator: first-fit run allocation over a ring of frame cells.
//
// The frame states sit in a ring of MAX_FRAMES cells that rotates by one cell
// per clock while an operation is under way; the controller sees one frame per
// cycle at the head of the ring and writes the updated state back at the tail,
// so after a full rotation the ring is aligned again. Release, mark and init
// each take one full rotation plus the handshake and result; an alloc takes
// one rotation to find the first fitting run and a second to claim it, or one
// rotation if nothing fits. An alloc on an empty pool, an alloc or mark of zero
// frames and a release or mark whose address lies outside the pool are answered
// without touching the ring. One request is in work at a time; a new request
// is taken while the previous result still waits in the output register.
// Configuration writes are always accepted and must only be issued while the
// block is idle. The ring needs no clearing pass after reset.
module contiguous_frame_allocator
#(
    parameter int MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  cfa_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output cfa_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [cfa_pkg::ADDR_W-1:0] cfg_data
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    // Comparison width wide enough for a frame index and an 11-bit length.
    localparam int CW = (IW + 1 > 12) ? IW + 1 : 12;
    localparam int AW = cfa_pkg::ADDR_W;
    localparam int LW = cfa_pkg::LEN_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAMES);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_FRAMES - 1);
    localparam logic [LW-1:0] FREE_RST = LW'((MAX_FRAMES < 1024) ? MAX_FRAMES : 1024);
    localparam logic [LW-1:0] CNT_MAX = {LW{1'b1}};

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SEARCH  = 6'b000010,
        S_CLAIM   = 6'b000100,
        S_RELEASE = 6'b001000,
        S_INIT    = 6'b010000,
        S_RESULT  = 6'b100000
    } fsm_t;

    fsm_t state_reg, state_next;

    // Configuration registers.
    logic [AW-1:0] pool_base_reg;
    logic [LW-1:0] pool_size_reg;
    logic          info_reg;

    // Work registers.
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] start_reg, start_next;
    logic [LW-1:0] len_reg, len_next;
    logic [CW-1:0] run_reg, run_next;
    logic          flag_reg, flag_next;   // found (search), bad (release)
    logic          walk_reg, walk_next;
    logic [LW-1:0] free_reg, free_next;
    logic [AW-1:0] res_first_reg, res_first_next;
    cfa_pkg::status_t res_status_reg, res_status_next;
    logic          rsp_valid_reg, rsp_valid_next;
    cfa_pkg::rsp_t rsp_reg, rsp_next;

    cfa_pkg::chain_ctl_t ctl;
    logic [1:0]    cur;

    // Effective pool size and the position of the request address.
    logic [CW-1:0] n_c;
    logic [AW-1:0] rel_full;
    logic          in_pool;
    logic [CW-1:0] idx_c;
    logic          idx_in;
    logic [IW-1:0] diff;
    logic          in_run;
    logic          dec, inc;

    assign n_c = ((CW'(pool_size_reg) < MAX_C) ? CW'(pool_size_reg) : MAX_C);
    assign rel_full = req.frame_addr - pool_base_reg;
    // The pool size is always narrower than a frame address.
    assign in_pool = (req.frame_addr >= pool_base_reg) && (rel_full < AW'(n_c));
    assign idx_c = CW'(idx_reg);
    assign idx_in = idx_c < n_c;
    assign diff = idx_reg - start_reg;
    assign in_run = (idx_reg >= start_reg) && (CW'(diff) < CW'(len_reg)) && idx_in;

    cfa_chain #(.MAX_FRAMES(MAX_FRAMES)) u_chain
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .head  (cur)
    );

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        run_next        = run_reg;
        flag_next       = flag_reg;
        walk_next       = walk_reg;
        res_first_next  = res_first_reg;
        res_status_next = res_status_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        ctl.shift       = 1'b0;
        ctl.tail        = cur;
        dec             = 1'b0;
        inc             = 1'b0;
        free_next       = free_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_first_next  = '0;
                    res_status_next = cfa_pkg::ST_OK;
                    idx_next        = '0;
                    len_next        = req.run_len;
                    start_next      = IW'(rel_full);
                    unique case (cfa_pkg::op_t'(req.op))
                        cfa_pkg::OP_ALLOC:
                        begin
                            run_next  = '0;
                            flag_next = 1'b0;
                            if (free_reg == '0)
                            begin
                                res_status_next = cfa_pkg::ST_EMPTY;
                                state_next = S_RESULT;
                            end
                            else if (req.run_len == '0)
                            begin
                                res_status_next = cfa_pkg::ST_NO_FIT;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        cfa_pkg::OP_RELEASE:
                        begin
                            flag_next = 1'b1;
                            walk_next = 1'b0;
                            if (!in_pool)
                            begin
                                res_status_next = cfa_pkg::ST_BAD_ADDR;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_RELEASE;
                            end
                        end
                        cfa_pkg::OP_MARK:
                        begin
                            if (req.run_len == '0)
                            begin
                                res_status_next = cfa_pkg::ST_NO_FIT;
                                state_next = S_RESULT;
                            end
                            else if (!in_pool)
                            begin
                                res_status_next = cfa_pkg::ST_BAD_ADDR;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                state_next = S_CLAIM;
                            end
                        end
                        cfa_pkg::OP_INIT:
                        begin
                            free_next  = LW'(n_c);
                            state_next = S_INIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                ctl.shift = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (!flag_reg && idx_in)
                begin
                    run_next = (cur == cfa_pkg::FS_FREE) ? run_reg + 1'b1 : '0;
                    if (run_next == CW'(len_reg))
                    begin
                        flag_next  = 1'b1;
                        start_next = IW'(idx_c + CW'(1) - CW'(len_reg));
                    end
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next = '0;
                    if (flag_next)
                    begin
                        res_first_next = pool_base_reg + AW'(start_next);
                        state_next = S_CLAIM;
                    end
                    else
                    begin
                        res_status_next = cfa_pkg::ST_NO_FIT;
                        state_next = S_RESULT;
                    end
                end
            end
            S_CLAIM:
            begin
                ctl.shift = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (in_run)
                begin
                    dec = (cur == cfa_pkg::FS_FREE);
                    ctl.tail = (idx_reg == start_reg) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_RESULT;
                end
            end
            S_RELEASE:
            begin
                ctl.shift = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == start_reg)
                begin
                    if (cur == cfa_pkg::FS_HEAD)
                    begin
                        flag_next = 1'b0;
                        walk_next = 1'b1;
                        inc       = 1'b1;
                        ctl.tail  = cfa_pkg::FS_FREE;
                    end
                end
                else if (walk_reg)
                begin
                    if (idx_in && cur == cfa_pkg::FS_USED)
                    begin
                        inc      = 1'b1;
                        ctl.tail = cfa_pkg::FS_FREE;
                    end
                    else
                    begin
                        walk_next = 1'b0;
                    end
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next = '0;
                    res_status_next = flag_next ? cfa_pkg::ST_BAD_ADDR : cfa_pkg::ST_OK;
                    state_next = S_RESULT;
                end
            end
            S_INIT:
            begin
                ctl.shift = 1'b1;
                idx_next  = idx_reg + 1'b1;
                ctl.tail  = cfa_pkg::FS_FREE;
                if (idx_reg == '0 && info_reg && n_c != '0)
                begin
                    ctl.tail = cfa_pkg::FS_USED;
                    dec      = 1'b1;
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.first_frame = res_first_reg;
                    rsp_next.status      = res_status_reg;
                    rsp_next.free_count  = free_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Saturating free-frame counter.
        if (dec && free_next != '0)
        begin
            free_next = free_next - 1'b1;
        end
        else if (inc && free_next != CNT_MAX)
        begin
            free_next = free_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            free_reg       <= FREE_RST;
            rsp_valid_reg  <= 1'b0;
            pool_base_reg  <= '0;
            pool_size_reg  <= LW'(1024);
            info_reg       <= 1'b1;
            flag_reg       <= 1'b0;
            walk_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
            flag_reg      <= flag_next;
            walk_reg      <= walk_next;
            if (cfg_valid)
            begin
                unique case (cfa_pkg::cfg_idx_t'(cfg_index))
                    cfa_pkg::CFG_POOL_BASE:    pool_base_reg <= cfg_data;
                    cfa_pkg::CFG_POOL_SIZE:    pool_size_reg <= cfg_data[LW-1:0];
                    cfa_pkg::CFG_INFO_IN_POOL: info_reg <= cfg_data[0];
                    default:                   info_reg <= info_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        len_reg        <= len_next;
        run_reg        <= run_next;
        res_first_reg  <= res_first_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // The ring must be back in alignment whenever no request is in work.
    a_aligned_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> idx_reg == '0)
        else $error("frame ring not aligned while idle");

    // A search or claim rotation advances by exactly one frame per cycle.
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH || state_reg == S_CLAIM) && idx_reg != LAST_IDX
        |=> idx_reg == $past(idx_reg) + 1'b1)
        else $error("frame index skipped during rotation");

    // Failed requests never report a frame number.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status != cfa_pkg::ST_OK |-> rsp_reg.first_frame == '0)
        else $error("failed request reports a frame number");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench of the contiguous frame allocator with its own prediction of the pool.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfa_pkg::*;

    localparam int NFR     = 1024;
    localparam int CNT_TOP = 2047;
    localparam int PER_PHASE = 54;
    // One transfer can take two full rotations of the ring, plus handshake.
    localparam int SETTLE  = 2 * NFR + 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [ADDR_W-1:0] cfg_data = '0;

    contiguous_frame_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the pool: frame states, free counter and the registers.
    frame_st_t pool_st [NFR];
    int        free_cnt;
    int        base_reg;
    int        size_reg;
    bit        info_reg;

    req_t pending_reqs [$];
    rsp_t expected_rsps [$];
    int   live_heads [$];
    int   fails = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;

    function automatic int pool_len();
        return (size_reg < NFR) ? size_reg : NFR;
    endfunction

    function automatic void cnt_down();
        if (free_cnt > 0)
            free_cnt--;
    endfunction

    function automatic void cnt_up();
        if (free_cnt < CNT_TOP)
            free_cnt++;
    endfunction

    // Claims a run starting at a relative frame, clipped at the pool end.
    function automatic void claim(int start, int len);
        int n;
        n = pool_len();
        for (int k = 0; k < len && start + k < n; k++)
        begin
            if (pool_st[start + k] == FS_FREE)
                cnt_down();
            pool_st[start + k] = (k == 0) ? FS_HEAD : FS_USED;
        end
    endfunction

    function automatic void clear_pool();
        foreach (pool_st[i])
            pool_st[i] = FS_FREE;
        free_cnt = pool_len();
        if (info_reg && pool_len() > 0)
        begin
            pool_st[0] = FS_USED;
            cnt_down();
        end
        live_heads.delete();
    endfunction

    // Applies one accepted request to the shadow pool and returns its answer.
    function automatic rsp_t allocate_predict(req_t r);
        rsp_t o;
        int n, addr, len, rel, run, i;
        bit hit, inside_pool;
        n = pool_len();
        addr = int'(r.frame_addr);
        len = int'(r.run_len);
        o = '0;
        o.status = ST_OK;
        inside_pool = (addr >= base_reg) && (addr - base_reg < n);
        rel = addr - base_reg;
        case (op_t'(r.op))
            OP_ALLOC:
            begin
                if (free_cnt == 0)
                    o.status = ST_EMPTY;
                else if (len == 0)
                    o.status = ST_NO_FIT;
                else
                begin
                    hit = 1'b0;
                    run = 0;
                    for (i = 0; i < n; i++)
                    begin
                        run = (pool_st[i] == FS_FREE) ? run + 1 : 0;
                        if (run == len)
                        begin
                            hit = 1'b1;
                            break;
                        end
                    end
                    if (!hit)
                        o.status = ST_NO_FIT;
                    else
                    begin
                        claim(i + 1 - len, len);
                        o.first_frame = ADDR_W'(i + 1 - len + base_reg);
                        live_heads.push_back(int'(o.first_frame));
                    end
                end
            end
            OP_RELEASE:
            begin
                if (!inside_pool || pool_st[rel] != FS_HEAD)
                    o.status = ST_BAD_ADDR;
                else
                begin
                    pool_st[rel] = FS_FREE;
                    cnt_up();
                    for (i = rel + 1; i < n && pool_st[i] == FS_USED; i++)
                    begin
                        pool_st[i] = FS_FREE;
                        cnt_up();
                    end
                end
            end
            OP_MARK:
            begin
                if (len == 0)
                    o.status = ST_NO_FIT;
                else if (!inside_pool)
                    o.status = ST_BAD_ADDR;
                else
                begin
                    claim(rel, len);
                    live_heads.push_back(addr);
                end
            end
            default:
                clear_pool();
        endcase
        o.free_count = LEN_W'(free_cnt);
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    // Driver: a new request is presented only once the previous one has gone.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (!req_valid || req_ready)
        begin
            if (req_valid)
                expected_rsps.push_back(allocate_predict(req));
            if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: every result transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                report_mismatch("unexpected result, status", int'(rsp.status), -1);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.first_frame !== want.first_frame)
                    report_mismatch("first_frame", int'(rsp.first_frame),
                                    int'(want.first_frame));
                if (rsp.status !== want.status)
                    report_mismatch("status", int'(rsp.status), int'(want.status));
                if (rsp.free_count !== want.free_count)
                    report_mismatch("free_count", int'(rsp.free_count),
                                    int'(want.free_count));
            end
        end
    end

    // Hands one request to the driver once the previous one has been taken,
    // so that stimulus built from the live heads follows the pool closely.
    task automatic send(op_t op, int addr, int len);
        req_t r;
        while (pending_reqs.size() != 0)
            @(posedge clk);
        r.op = op;
        r.frame_addr = ADDR_W'(addr);
        r.run_len = LEN_W'(len);
        pending_reqs.push_back(r);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    // One configuration transfer, with cfg_valid dropped again before the next.
    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= ADDR_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_POOL_BASE:    base_reg = value & 32'hFFFFF;
            CFG_POOL_SIZE:    size_reg = value & 32'h7FF;
            CFG_INFO_IN_POOL: info_reg = value[0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // Random request: mostly well-formed allocs, releases of live heads and
    // marks inside the pool, with some inits and fully random noise.
    task automatic send_random();
        int pick, len, addr, idx, n;
        n = pool_len();
        pick = $urandom_range(99);
        addr = $urandom_range(32'hFFFFF);
        if (pick < 45)
        begin
            len = $urandom_range(99);
            if (len < 70)
                len = $urandom_range(8, 1);
            else if (len < 85)
                len = $urandom_range(n, 1);
            else if (len < 92)
                len = 0;
            else
                len = $urandom_range(CNT_TOP);
            send(OP_ALLOC, addr, len);
        end
        else if (pick < 75)
        begin
            if (live_heads.size() > 0 && $urandom_range(9) < 8)
            begin
                idx = $urandom_range(live_heads.size() - 1);
                addr = live_heads[idx];
                live_heads.delete(idx);
            end
            else if ($urandom_range(1))
                addr = (base_reg + $urandom_range(n - 1)) & 32'hFFFFF;
            send(OP_RELEASE, addr, $urandom_range(CNT_TOP));
        end
        else if (pick < 90)
            send(OP_MARK, (base_reg + $urandom_range(n - 1)) & 32'hFFFFF,
                 $urandom_range(16, 1));
        else if (pick < 93)
            send(OP_INIT, addr, $urandom_range(CNT_TOP));
        else
            send(op_t'($urandom_range(3)), addr, $urandom_range(CNT_TOP));
    endtask

    task automatic run_phase(int mode, bit do_init);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 50; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 50; end
            default: begin idle_pct = 6; stall_pct = 6; end
        endcase
        if (do_init)
            send(OP_INIT, 0, 0);
        repeat (PER_PHASE)
            send_random();
        wait_idle();
    endtask

    initial
    begin
        base_reg = 0;
        size_reg = NFR;
        info_reg = 1'b1;
        foreach (pool_st[i])
            pool_st[i] = FS_FREE;
        free_cnt = NFR;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset configuration.
        send(OP_ALLOC, 0, 1);
        send(OP_INIT, 32'hFFFFF, CNT_TOP);
        send(OP_ALLOC, 0, 0);
        send(OP_ALLOC, 0, NFR);
        send(OP_ALLOC, 32'hFFFFF, NFR - 1);
        send(OP_ALLOC, 0, 1);
        send(OP_RELEASE, 1, 0);
        send(OP_RELEASE, 2, 0);
        send(OP_RELEASE, 0, 0);
        send(OP_RELEASE, 32'hFFFFF, 0);
        send(OP_MARK, 3, 0);
        send(OP_MARK, NFR, 4);
        send(OP_MARK, NFR - 4, 10);
        send(OP_MARK, 1, 5);
        send(OP_ALLOC, 0, 3);
        send(OP_RELEASE, NFR - 4, CNT_TOP);
        send(OP_ALLOC, 0, CNT_TOP);
        send(OP_INIT, 0, 0);
        wait_idle();

        run_phase(0, 1'b0);

        // Pool at the top of the address space, so results wrap around.
        write_reg(CFG_POOL_BASE, 32'hFFFF0);
        write_reg(CFG_POOL_SIZE, 64);
        write_reg(CFG_INFO_IN_POOL, 0);
        run_phase(1, 1'b1);

        // Single-frame pool that is full straight after init.
        write_reg(CFG_POOL_BASE, 12345);
        write_reg(CFG_POOL_SIZE, 1);
        write_reg(CFG_INFO_IN_POOL, 1);
        run_phase(2, 1'b1);

        // Oversized setting is clipped to the store depth.
        write_reg(CFG_POOL_BASE, 0);
        write_reg(CFG_POOL_SIZE, CNT_TOP);
        write_reg(CFG_INFO_IN_POOL, 0);
        run_phase(3, 1'b1);

        write_reg(CFG_POOL_BASE, 32'h80000);
        write_reg(CFG_POOL_SIZE, 16);
        write_reg(CFG_INFO_IN_POOL, 1);
        run_phase(0, 1'b1);

        // Pool grows without an init, so the counter no longer matches it.
        write_reg(CFG_POOL_SIZE, NFR);
        run_phase(1, 1'b0);

        // A write to the spare index must change nothing.
        write_reg(CFG_NONE, 32'h5A5A5);
        write_reg(CFG_POOL_BASE, 32'hFFFFF);
        run_phase(2, 1'b1);
        write_reg(CFG_POOL_BASE, 100);
        write_reg(CFG_POOL_SIZE, 200);
        run_phase(3, 1'b1);

        repeat (SETTLE)
            @(posedge clk);
        if (fails == 0 && expected_rsps.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
rtl/cfa_pkg.sv
rtl/cfa_cell.sv
rtl/cfa_chain.sv
rtl/contiguous_frame_allocator.sv
test/tb.sv
